>>> rtl/multichannel_biquad_lowpass_defines.svh
// assertion macros shared by the biquad filter rtl
`ifndef MULTICHANNEL_BIQUAD_LOWPASS_DEFINES_SVH
`define MULTICHANNEL_BIQUAD_LOWPASS_DEFINES_SVH

// same-cycle implication, checked on clk, off while rst_n is low
`define MBL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off while rst_n is low
`define MBL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mbl_pkg.sv
// types and constants of the multichannel biquad lowpass
package mbl_pkg;

  localparam int CHAN_W   = 3;
  localparam int SAMPLE_W = 32;
  localparam int COEF_W   = 32;
  localparam int FRAC_W   = 30;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  // b0 * (x + 2*x1 + x2): feedforward sum carries three extra bits
  localparam int FSUM_W = SAMPLE_W + 3;
  // exact Q21.46 accumulator of all terms
  localparam int ACC_W  = COEF_W + FSUM_W;
  // accumulator after dropping the fraction bits
  localparam int RND_W  = ACC_W - FRAC_W;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;
  localparam logic signed [ACC_W-1:0]    HALF_LSB   = ACC_W'(1) <<< (FRAC_W - 1);

  typedef enum logic {
    OP_FILTER = 1'b0,
    OP_PRESET = 1'b1
  } op_t;

  // register index codes, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_B0   = 2'd0,
    REG_A1   = 2'd1,
    REG_A2   = 2'd2,
    REG_NONE = 2'd3
  } reg_idx_t;

  // one channel's history row
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [SAMPLE_W-1:0] y1;
    logic signed [SAMPLE_W-1:0] y2;
  } hist_t;

endpackage

>>> rtl/mbl_ifs.sv
// valid/ready channel interfaces for the biquad input and result words
interface mbl_in_if;
  logic                                     valid;
  logic                                     ready;
  mbl_pkg::op_t                             operation;
  logic [mbl_pkg::CHAN_W-1:0]               channel;
  logic signed [mbl_pkg::SAMPLE_W-1:0]      sample;

  modport source (output valid, output operation, output channel, output sample,
                  input ready);
  modport sink   (input valid, input operation, input channel, input sample,
                  output ready);
endinterface

interface mbl_out_if;
  logic                                     valid;
  logic                                     ready;
  logic [mbl_pkg::CHAN_W-1:0]               out_channel;
  logic signed [mbl_pkg::SAMPLE_W-1:0]      filtered;
  logic                                     saturated;

  modport source (output valid, output out_channel, output filtered, output saturated,
                  input ready);
  modport sink   (input valid, input out_channel, input filtered, input saturated,
                  output ready);
endinterface

>>> rtl/multichannel_biquad_lowpass.sv
// top level: per-channel direct form I biquad lowpass with apb coefficients
//
//  port       | dir | handshake          | word
//  -----------+-----+--------------------+-----------------------------------------
//  in_word    | in  | valid/ready        | operation, channel, sample (q16.16)
//  out_word   | out | valid/ready        | out_channel, filtered (q16.16), saturated
//  apb        | in  | psel/penable/pready| coef_b0, coef_a1, coef_a2 (q2.30)
//
//  one word per cycle unless out_word stalls; out_word.valid is registered
//  stage 1 holds the word and its history row; products and sum feed the output register
//  a same-channel word right behind the previous one takes the history through a bypass
//  rst_n (synchronous, active low) clears coefficients, pipeline valids and the
//  per-channel history valid bits, so history reads as zero until first written
//  a stall on out_word holds stage 1; in_word stays ready while stage 1 can drain
`include "multichannel_biquad_lowpass_defines.svh"

module multichannel_biquad_lowpass #(
  parameter int CHANNELS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mbl_in_if.sink                        in_word,
  mbl_out_if.source                     out_word,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mbl_pkg::PADDR_W-1:0]   paddr,
  input  logic [mbl_pkg::PDATA_W-1:0]   pwdata,
  output logic [mbl_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import mbl_pkg::*;

  // history index width and a compare width that holds both channel and CHANNELS
  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CMP_W = ((IDX_W > CHAN_W) ? IDX_W : CHAN_W) + 2;

  // ---------------------------------------------------------------------------
  // coefficient registers
  // ---------------------------------------------------------------------------
  logic signed [COEF_W-1:0] coef_b0_r;
  logic signed [COEF_W-1:0] coef_a1_r;
  logic signed [COEF_W-1:0] coef_a2_r;
  reg_idx_t                 reg_idx;
  logic                     apb_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign apb_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_b0_r <= '0;
      coef_a1_r <= '0;
      coef_a2_r <= '0;
    end else if (apb_wr) begin
      case (reg_idx)
        REG_B0:  coef_b0_r <= signed'(pwdata);
        REG_A1:  coef_a1_r <= signed'(pwdata);
        REG_A2:  coef_a2_r <= signed'(pwdata);
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_B0:  prdata = coef_b0_r;
      REG_A1:  prdata = coef_a1_r;
      REG_A2:  prdata = coef_a2_r;
      default: prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshake and stage control
  // ---------------------------------------------------------------------------
  logic s1_v_r;
  logic out_v_r;
  logic s1_adv;     // stage 1 word moves into the output register
  logic in_acc;     // input word taken this cycle

  assign s1_adv        = s1_v_r && (!out_v_r || out_word.ready);
  assign in_word.ready = !s1_v_r || s1_adv;
  assign in_acc        = in_word.valid && in_word.ready;

  // channel range check and memory index of the incoming word
  logic [CMP_W-1:0] in_ch_ext;
  logic             in_ok;
  logic [IDX_W-1:0] in_idx;

  assign in_ch_ext = CMP_W'(in_word.channel);
  assign in_ok     = in_ch_ext < CMP_W'(CHANNELS);
  assign in_idx    = IDX_W'(in_ch_ext);

  // ---------------------------------------------------------------------------
  // stage 1: input word, history read
  // ---------------------------------------------------------------------------
  op_t                        s1_op_r;
  logic [CHAN_W-1:0]          s1_ch_r;
  logic signed [SAMPLE_W-1:0] s1_sample_r;
  logic                       s1_ok_r;
  logic [IDX_W-1:0]           s1_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_word.ready) begin
      s1_v_r <= in_word.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r     <= in_word.operation;
      s1_ch_r     <= in_word.channel;
      s1_sample_r <= in_word.sample;
      s1_ok_r     <= in_ok;
      s1_idx_r    <= in_idx;
    end
  end

  // history memory, one row per channel, with a valid bit per row
  hist_t                hist_mem [CHANNELS];
  logic [CHANNELS-1:0]  hist_vld_r;
  hist_t                hist_q_r;     // registered memory read
  hist_t                byp_row_r;    // row written on the read edge
  logic                 byp_r;
  logic                 rd_vld_r;
  hist_t                hist_cur;     // history seen by stage 1
  hist_t                hist_wr;
  logic                 hist_we;

  assign hist_we = s1_adv && s1_ok_r;

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[s1_idx_r] <= hist_wr;
    end
    if (in_acc) begin
      hist_q_r <= hist_mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r <= '0;
    end else if (hist_we) begin
      hist_vld_r[s1_idx_r] <= 1'b1;
    end
  end

  // a write to the row being read on the same edge wins over the old contents
  always_ff @(posedge clk) begin
    if (in_acc) begin
      byp_r     <= hist_we && (s1_idx_r == in_idx);
      byp_row_r <= hist_wr;
      rd_vld_r  <= in_ok && hist_vld_r[in_idx];
    end
  end

  always_comb begin
    if (byp_r) begin
      hist_cur = byp_row_r;
    end else if (rd_vld_r) begin
      hist_cur = hist_q_r;
    end else begin
      hist_cur = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // filter arithmetic: y = b0*(x + 2*x1 + x2) - a1*y1 - a2*y2, q21.46 exact
  // ---------------------------------------------------------------------------
  logic signed [FSUM_W-1:0] fsum;
  logic signed [ACC_W-1:0]  prod_b;
  logic signed [ACC_W-1:0]  prod_a1;
  logic signed [ACC_W-1:0]  prod_a2;
  logic signed [ACC_W-1:0]  acc;
  logic signed [RND_W-1:0]  acc_rnd;
  logic signed [SAMPLE_W-1:0] y_filt;
  logic                     y_sat;
  logic signed [SAMPLE_W-1:0] y_res;
  logic                     sat_res;

  assign fsum    = FSUM_W'(s1_sample_r) + (FSUM_W'(hist_cur.x1) <<< 1)
                 + FSUM_W'(hist_cur.x2);
  assign prod_b  = ACC_W'(coef_b0_r) * ACC_W'(fsum);
  assign prod_a1 = ACC_W'(coef_a1_r) * ACC_W'(hist_cur.y1);
  assign prod_a2 = ACC_W'(coef_a2_r) * ACC_W'(hist_cur.y2);
  assign acc     = prod_b - prod_a1 - prod_a2 + HALF_LSB;
  // floor shift gives round to nearest, ties upward
  assign acc_rnd = RND_W'(acc >>> FRAC_W);

  always_comb begin
    if (acc_rnd > RND_W'(SAMPLE_MAX)) begin
      y_filt = SAMPLE_MAX;
      y_sat  = 1'b1;
    end else if (acc_rnd < RND_W'(SAMPLE_MIN)) begin
      y_filt = SAMPLE_MIN;
      y_sat  = 1'b1;
    end else begin
      y_filt = SAMPLE_W'(acc_rnd);
      y_sat  = 1'b0;
    end
  end

  // result and history update per operation
  always_comb begin
    hist_wr = hist_cur;
    y_res   = '0;
    sat_res = 1'b0;
    if (s1_ok_r) begin
      case (s1_op_r)
        OP_PRESET: begin
          hist_wr = '{x1: s1_sample_r, x2: s1_sample_r, y1: s1_sample_r,
                      y2: s1_sample_r};
          y_res   = s1_sample_r;
        end
        OP_FILTER: begin
          hist_wr = '{x1: s1_sample_r, x2: hist_cur.x1, y1: y_filt,
                      y2: hist_cur.y1};
          y_res   = y_filt;
          sat_res = y_sat;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic [CHAN_W-1:0]          out_ch_r;
  logic signed [SAMPLE_W-1:0] out_filt_r;
  logic                       out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (out_word.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_ch_r   <= s1_ch_r;
      out_filt_r <= y_res;
      out_sat_r  <= sat_res;
    end
  end

  assign out_word.valid       = out_v_r;
  assign out_word.out_channel = out_ch_r;
  assign out_word.filtered    = out_filt_r;
  assign out_word.saturated   = out_sat_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `MBL_ASSERT_IMP(a_sat_clamped, out_v_r && out_sat_r,
    (out_filt_r == SAMPLE_MAX) || (out_filt_r == SAMPLE_MIN),
    "saturated word not at a range limit")
  `MBL_ASSERT_NXT(a_preset_echo, s1_adv && s1_ok_r && (s1_op_r == OP_PRESET),
    (out_filt_r == $past(s1_sample_r)) && !out_sat_r,
    "preset word does not echo the sample")
  `MBL_ASSERT_NXT(a_bad_chan_zero, s1_adv && !s1_ok_r,
    (out_filt_r == '0) && !out_sat_r,
    "out-of-range channel gave a nonzero result")
  `MBL_ASSERT_IMP(a_stall_only_full, !in_word.ready,
    s1_v_r && out_v_r && !out_word.ready,
    "input stalled while the pipeline can drain")

endmodule
